// ===== rtl/core/plbr_pkg.sv =====
// Shared types and constants for the piecewise-linear breakpoint remapper.
// No dependencies; used by plbr_chan and the top level.
package plbr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int DIV_STEPS = 16;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MAP  = 1'b1
	} op_t;

	typedef enum logic {
		MODE_ALL  = 1'b0,
		MODE_SKIP = 1'b1
	} seg_mode_t;

	// selected segment, after lookup
	typedef struct packed {
		logic                       hit;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] sa;
		logic signed [SAMPLE_W-1:0] sb;
		logic signed [SAMPLE_W-1:0] ta;
		logic signed [SAMPLE_W-1:0] tb;
	} sel_t;

	// segment differences
	typedef struct packed {
		logic                       hit;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] ta;
		logic signed [SAMPLE_W:0]   d;
		logic signed [SAMPLE_W:0]   dt;
		logic [SAMPLE_W-1:0]        den;
	} diff_t;

	// product
	typedef struct packed {
		logic                         hit;
		logic signed [SAMPLE_W-1:0]   x;
		logic signed [SAMPLE_W-1:0]   ta;
		logic signed [2*SAMPLE_W+1:0] prod;
		logic [SAMPLE_W-1:0]          den;
	} prod_t;

	// one divider step
	typedef struct packed {
		logic                       hit;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] ta;
		logic                       neg;
		logic [SAMPLE_W-1:0]        rem;
		logic [SAMPLE_W-1:0]        low;
		logic [SAMPLE_W-1:0]        quo;
		logic [SAMPLE_W-1:0]        den;
	} div_t;

endpackage

// ===== rtl/core/plbr_chan.sv =====
// One channel of the remapper: breakpoint table, segment lookup, multiply,
// 16-step pipelined divider and saturating output. Depends on plbr_pkg.
module plbr_chan import plbr_pkg::*; #(
	parameter int BREAKPOINT_COUNT = 7
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       ld_en,
	input  logic [2:0]                 ld_idx,
	input  logic signed [SAMPLE_W-1:0] ld_src,
	input  logic signed [SAMPLE_W-1:0] ld_tgt,
	input  logic                       mode,
	input  logic signed [SAMPLE_W-1:0] x_in,
	output logic signed [SAMPLE_W-1:0] y_out,
	output logic                       hit_out
);

	localparam int N     = BREAKPOINT_COUNT;
	localparam int NSEG0 = N - 1;
	localparam int NPT1  = (N == 3) ? N - 1 : N - 2;
	localparam int NSEG1 = NPT1 - 1;
	localparam logic signed [SAMPLE_W+1:0] SAT_HI = (1 <<< (SAMPLE_W - 1)) - 1;
	localparam logic signed [SAMPLE_W+1:0] SAT_LO = -(1 <<< (SAMPLE_W - 1));

	// breakpoint position of point k when breakpoints 1 and N-2 are skipped
	function automatic int pt1(input int k);
		int n;
		int r;
		n = 0;
		r = 0;
		for (int i = 0; i < N; i++) begin
			if (!(i == 1 || i == N - 2)) begin
				if (n == k) r = i;
				n++;
			end
		end
		return r;
	endfunction

	logic signed [SAMPLE_W-1:0] src_q [N];
	logic signed [SAMPLE_W-1:0] tgt_q [N];

	// table write
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (ld_en && int'(ld_idx) == i) begin
				src_q[i] <= ld_src;
				tgt_q[i] <= ld_tgt;
			end
		end
	end

	// segment lookup: first match wins, so scan from the top down
	sel_t sel;
	always_comb begin
		sel    = '0;
		sel.x  = x_in;
		if (mode == MODE_SKIP) begin
			for (int k = NSEG1 - 1; k >= 0; k--) begin
				if (src_q[pt1(k)] <= x_in &&
				    ((k == NSEG1 - 1) ? (x_in <= src_q[pt1(k + 1)])
				                      : (x_in <  src_q[pt1(k + 1)]))) begin
					sel.hit = 1'b1;
					sel.sa  = src_q[pt1(k)];
					sel.sb  = src_q[pt1(k + 1)];
					sel.ta  = tgt_q[pt1(k)];
					sel.tb  = tgt_q[pt1(k + 1)];
				end
			end
		end else begin
			for (int k = NSEG0 - 1; k >= 0; k--) begin
				if (src_q[k] <= x_in &&
				    ((k == NSEG0 - 1) ? (x_in <= src_q[k + 1])
				                      : (x_in <  src_q[k + 1]))) begin
					sel.hit = 1'b1;
					sel.sa  = src_q[k];
					sel.sb  = src_q[k + 1];
					sel.ta  = tgt_q[k];
					sel.tb  = tgt_q[k + 1];
				end
			end
		end
	end

	sel_t  sel_s1;
	diff_t diff_s2;
	prod_t prod_s3;
	div_t  div_s [DIV_STEPS+1];
	logic signed [SAMPLE_W:0] den_w;

	assign den_w = 17'(sel_s1.sb) - 17'(sel_s1.sa);

	// lookup, differences, product
	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1       <= sel;
			diff_s2.hit  <= sel_s1.hit;
			diff_s2.x    <= sel_s1.x;
			diff_s2.ta   <= sel_s1.ta;
			diff_s2.d    <= sel_s1.hit ? (17'(sel_s1.x) - 17'(sel_s1.sa)) : '0;
			diff_s2.dt   <= 17'(sel_s1.tb) - 17'(sel_s1.ta);
			// zero-width segment: d is zero, any nonzero divisor gives zero
			diff_s2.den  <= (den_w[SAMPLE_W-1:0] == '0) ? SAMPLE_W'(1)
			                                            : den_w[SAMPLE_W-1:0];
			prod_s3.hit  <= diff_s2.hit;
			prod_s3.x    <= diff_s2.x;
			prod_s3.ta   <= diff_s2.ta;
			prod_s3.prod <= 34'(diff_s2.d) * 34'(diff_s2.dt);
			prod_s3.den  <= diff_s2.den;
		end
	end

	// divider setup: sign and magnitude
	logic [2*SAMPLE_W+1:0] mag;
	assign mag = prod_s3.prod[2*SAMPLE_W+1] ? 34'(-prod_s3.prod) : 34'(prod_s3.prod);

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].hit <= prod_s3.hit;
			div_s[0].x   <= prod_s3.x;
			div_s[0].ta  <= prod_s3.ta;
			div_s[0].neg <= prod_s3.prod[2*SAMPLE_W+1];
			div_s[0].rem <= mag[2*SAMPLE_W-1:SAMPLE_W];
			div_s[0].low <= mag[SAMPLE_W-1:0];
			div_s[0].quo <= '0;
			div_s[0].den <= prod_s3.den;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		logic [SAMPLE_W:0] trial;
		logic              take;
		assign trial = {div_s[g].rem, div_s[g].low[SAMPLE_W-1]};
		assign take  = trial >= {1'b0, div_s[g].den};
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g+1].hit <= div_s[g].hit;
				div_s[g+1].x   <= div_s[g].x;
				div_s[g+1].ta  <= div_s[g].ta;
				div_s[g+1].neg <= div_s[g].neg;
				div_s[g+1].den <= div_s[g].den;
				div_s[g+1].rem <= take ? SAMPLE_W'(trial - {1'b0, div_s[g].den})
				                       : trial[SAMPLE_W-1:0];
				div_s[g+1].low <= {div_s[g].low[SAMPLE_W-2:0], 1'b0};
				div_s[g+1].quo <= {div_s[g].quo[SAMPLE_W-2:0], take};
			end
		end
	end

	// signed quotient, add target start, saturate; a sample outside the table passes through
	logic signed [SAMPLE_W+1:0] q_sig;
	logic signed [SAMPLE_W+1:0] sum;
	assign q_sig = div_s[DIV_STEPS].neg ? -18'(div_s[DIV_STEPS].quo)
	                                    : 18'(div_s[DIV_STEPS].quo);
	assign sum   = 18'(div_s[DIV_STEPS].ta) + q_sig;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_out <= div_s[DIV_STEPS].hit;
			if (!div_s[DIV_STEPS].hit) y_out <= div_s[DIV_STEPS].x;
			else if (sum > SAT_HI)     y_out <= SAT_HI[SAMPLE_W-1:0];
			else if (sum < SAT_LO)     y_out <= SAT_LO[SAMPLE_W-1:0];
			else                       y_out <= sum[SAMPLE_W-1:0];
		end
	end

endmodule

// ===== rtl/core/piecewise_linear_breakpoint_remap.sv =====
// Channel   Handshake                Payload
// in        in_valid / in_ready      op, table_channel, table_index, points, cx_in, cy_in
// out       out_valid / out_ready    cx_out, cy_out, cx_in_range, cy_in_range
// cfg       APB write/read           segment_mode at byte address 0
//
// One map beat per cycle while out_ready does not stall the pipeline; each map beat
// passes through 21 register stages (lookup, differences, multiply, divider setup, 16 divider
// steps, output) after it is accepted.
// Load beats write the table at acceptance and produce no result.
// The whole pipeline holds while the output register waits on out_ready.
// Reset clears valid bits and segment_mode; the table is unknown until loaded.
// Depends on plbr_pkg and plbr_chan.
module piecewise_linear_breakpoint_remap import plbr_pkg::*; #(
	parameter int BREAKPOINT_COUNT = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic                       table_channel,
	input  logic [2:0]                 table_index,
	input  logic signed [SAMPLE_W-1:0] source_point,
	input  logic signed [SAMPLE_W-1:0] target_point,
	input  logic signed [SAMPLE_W-1:0] cx_in,
	input  logic signed [SAMPLE_W-1:0] cy_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] cx_out,
	output logic signed [SAMPLE_W-1:0] cy_out,
	output logic                       cx_in_range,
	output logic                       cy_in_range
);

	localparam int DEPTH = DIV_STEPS + 5;

	logic             mode_q;
	logic [DEPTH-1:0] vld_q;
	logic             adv;
	logic             acc;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'b0, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ALL;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			mode_q <= pwdata[0];
		end
	end

	// global advance: move when the output slot is free or being drained
	assign adv       = !vld_q[DEPTH-1] || out_ready;
	assign in_ready  = adv;
	assign acc       = in_valid && in_ready;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], acc && op == OP_MAP};
		end
	end

	// channel datapaths
	plbr_chan #(.BREAKPOINT_COUNT(BREAKPOINT_COUNT)) u_cx (
		.clk    (clk),
		.en     (adv),
		.ld_en  (acc && op == OP_LOAD && table_channel == 1'b0),
		.ld_idx (table_index),
		.ld_src (source_point),
		.ld_tgt (target_point),
		.mode   (mode_q),
		.x_in   (cx_in),
		.y_out  (cx_out),
		.hit_out(cx_in_range)
	);

	plbr_chan #(.BREAKPOINT_COUNT(BREAKPOINT_COUNT)) u_cy (
		.clk    (clk),
		.en     (adv),
		.ld_en  (acc && op == OP_LOAD && table_channel == 1'b1),
		.ld_idx (table_index),
		.ld_src (source_point),
		.ld_tgt (target_point),
		.mode   (mode_q),
		.x_in   (cy_in),
		.y_out  (cy_out),
		.hit_out(cy_in_range)
	);

endmodule

// ===== rtl/core/plbr_checker.sv =====
// Port-level checks for the remapper, bound to the top level.
// Depends on plbr_pkg and piecewise_linear_breakpoint_remap.
module plbr_checker import plbr_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic [31:0]                prdata,
	input logic                       pready,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] cx_out,
	input logic signed [SAMPLE_W-1:0] cy_out
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cx_out) && $stable(cy_out))
		else $error("result beat changed while stalled");

	// input side stalls only behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// nothing comes out right after reset
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result beat right after reset");

	// config reads carry one bit and never wait
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		pready && prdata[31:1] == '0)
		else $error("config port misbehaves");

endmodule

bind piecewise_linear_breakpoint_remap plbr_checker u_plbr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.prdata   (prdata),
	.pready   (pready),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.cx_out   (cx_out),
	.cy_out   (cy_out)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for piecewise_linear_breakpoint_remap.
// It predicts each mapped pair from its own table copy; depends on plbr_pkg and the RTL.
module testbench;
	import plbr_pkg::*;

	localparam int NPTS = 7;
	localparam int DRAIN_CYCLES = 30;

	typedef struct {
		logic signed [SAMPLE_W-1:0] cx;
		logic signed [SAMPLE_W-1:0] cy;
		bit                         cx_hit;
		bit                         cy_hit;
	} remap_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]                 paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       op = 1'b0;
	logic                       table_channel = 1'b0;
	logic [2:0]                 table_index = '0;
	logic signed [SAMPLE_W-1:0] source_point = '0, target_point = '0;
	logic signed [SAMPLE_W-1:0] cx_in = '0, cy_in = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] cx_out, cy_out;
	logic                       cx_in_range, cy_in_range;

	// predictor state
	logic signed [SAMPLE_W-1:0] src_tbl [2*NPTS];
	logic signed [SAMPLE_W-1:0] tgt_tbl [2*NPTS];
	seg_mode_t                  cur_mode = MODE_ALL;
	remap_t                     pending_remaps [$];
	int                         errors = 0;
	int                         beats_sent = 0;
	bit                         quiet = 1'b0;
	int                         src_lo [2], src_hi [2];

	piecewise_linear_breakpoint_remap dut (.*);

	always #1 clk = ~clk;

	// random back-pressure, off during quiet stretches
	always @(posedge clk)
		out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 14);

	function automatic logic signed [SAMPLE_W-1:0] remap_sample(bit ch,
			logic signed [SAMPLE_W-1:0] x, output bit hit);
		int     pts [NPTS];
		int     n;
		longint sa, sb, ta, tb, q, r;
		bit     last;
		n = 0;
		for (int i = 0; i < NPTS; i++) begin
			if (cur_mode == MODE_SKIP && (i == 1 || i == NPTS - 2))
				continue;
			pts[n++] = i;
		end
		for (int k = 0; k + 1 < n; k++) begin
			sa = src_tbl[ch*NPTS + pts[k]];
			sb = src_tbl[ch*NPTS + pts[k+1]];
			ta = tgt_tbl[ch*NPTS + pts[k]];
			tb = tgt_tbl[ch*NPTS + pts[k+1]];
			last = (k + 2 == n);
			if (sa <= x && (last ? (x <= sb) : (x < sb))) begin
				hit = 1'b1;
				q = (sb > sa) ? ((x - sa) * (tb - ta)) / (sb - sa) : 0;
				r = ta + q;
				if (r > 32767) r = 32767;
				if (r < -32768) r = -32768;
				return SAMPLE_W'(r);
			end
		end
		hit = 1'b0;
		return x;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker: values are stable at the falling edge
	always @(negedge clk) begin
		remap_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_remaps.size() == 0) begin
				report_mismatch("unexpected result beat", 1, 0);
			end else begin
				want = pending_remaps.pop_front();
				if (cx_out !== want.cx) report_mismatch("cx_out", cx_out, want.cx);
				if (cy_out !== want.cy) report_mismatch("cy_out", cy_out, want.cy);
				if (cx_in_range !== want.cx_hit)
					report_mismatch("cx_in_range", cx_in_range, want.cx_hit);
				if (cy_in_range !== want.cy_hit)
					report_mismatch("cy_in_range", cy_in_range, want.cy_hit);
			end
		end
	end

	// one input beat; entered and left just after a rising edge
	task automatic send_beat(op_t kind, bit ch, logic [2:0] idx,
			logic signed [SAMPLE_W-1:0] sp, logic signed [SAMPLE_W-1:0] tp,
			logic signed [SAMPLE_W-1:0] cx, logic signed [SAMPLE_W-1:0] cy);
		bit     taken;
		remap_t r;
		while (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= kind;
		table_channel <= ch;
		table_index   <= idx;
		source_point  <= sp;
		target_point  <= tp;
		cx_in         <= cx;
		cy_in         <= cy;
		do begin
			@(negedge clk);
			taken = in_ready;
			if (taken) begin
				if (kind == OP_LOAD) begin
					if (idx < NPTS) begin
						src_tbl[ch*NPTS + idx] = sp;
						tgt_tbl[ch*NPTS + idx] = tp;
					end
				end else begin
					r.cx = remap_sample(1'b0, cx, r.cx_hit);
					r.cy = remap_sample(1'b1, cy, r.cy_hit);
					pending_remaps.insert(pending_remaps.size(), r);
				end
			end
			@(posedge clk);
		end while (!taken);
		beats_sent++;
	endtask

	task automatic load_point(bit ch, logic [2:0] idx, int sp, int tp);
		send_beat(OP_LOAD, ch, idx, SAMPLE_W'(sp), SAMPLE_W'(tp),
			SAMPLE_W'($urandom), SAMPLE_W'($urandom));
	endtask

	task automatic map_pair(int cx, int cy);
		send_beat(OP_MAP, 1'($urandom), 3'($urandom), SAMPLE_W'($urandom),
			SAMPLE_W'($urandom), SAMPLE_W'(cx), SAMPLE_W'(cy));
	endtask

	// let every expected result arrive, then the pipeline settle
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_remaps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(seg_mode_t m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= '0;
		pwdata  <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cur_mode = m;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// table with full-range extremes and a repeated interior breakpoint
	task automatic test_table_extremes;
		int sx [NPTS] = '{-32768, -20000, -4096, 0, 4096, 20000, 32767};
		int tx [NPTS] = '{32767, -32768, 1000, 0, -1000, 32767, -32768};
		int sy [NPTS] = '{-100, -50, 0, 0, 50, 50, 100};
		int ty [NPTS] = '{-32768, 32767, 7, -7, 300, -300, 32767};
		for (int i = 0; i < NPTS; i++) begin
			load_point(1'b0, 3'(i), sx[i], tx[i]);
			load_point(1'b1, 3'(i), sy[i], ty[i]);
		end
		// position past the table is ignored
		load_point(1'b0, 3'd7, 12345, -12345);
		map_pair(-32768, -32768);
		map_pair(32767, 32767);
		map_pair(-20000, -100);
		map_pair(-4097, 100);
		map_pair(0, 0);
		map_pair(20000, 50);
		map_pair(-1, 25);
		map_pair(32766, 101);
		drain();
	endtask

	// last segment of zero width, a descending pair, both segment modes
	task automatic test_segment_shapes;
		int sy [NPTS] = '{-100, 300, 0, 50, 60, 200, 200};
		int ty [NPTS] = '{10, 20, 30, 40, 50, 60, 70};
		for (int i = 0; i < NPTS; i++)
			load_point(1'b1, 3'(i), sy[i], ty[i]);
		map_pair(0, 200);
		map_pair(-32768, 250);
		map_pair(4096, -100);
		drain();
		write_mode(MODE_SKIP);
		map_pair(-20000, 200);
		map_pair(0, 55);
		map_pair(32767, -1);
		map_pair(-4096, 199);
		drain();
		write_mode(MODE_ALL);
		map_pair(32767, 300);
		drain();
	endtask

	task automatic load_random_curve(bit ch);
		int  s [NPTS];
		bit  shuffle;
		shuffle = ($urandom_range(9) == 0);
		for (int i = 0; i < NPTS; i++)
			s[i] = $signed(SAMPLE_W'($urandom));
		if (!shuffle) begin
			s.sort();
			for (int i = 1; i < NPTS; i++)
				if ($urandom_range(9) == 0) s[i] = s[i-1];
		end
		src_lo[ch] = shuffle ? -32768 : s[0];
		src_hi[ch] = shuffle ? 32767 : s[NPTS-1];
		for (int i = 0; i < NPTS; i++)
			load_point(ch, 3'(i), s[i], $signed(SAMPLE_W'($urandom)));
	endtask

	function automatic int pick_sample(bit ch);
		if ($urandom_range(9) < 7)
			return src_lo[ch] + int'($urandom_range(src_hi[ch] - src_lo[ch]));
		return $signed(SAMPLE_W'($urandom));
	endfunction

	// random phases: fresh curves and at times a new mode, then a burst of mapped pairs
	task automatic test_random_phases(int item_goal);
		int burst;
		while (beats_sent < item_goal) begin
			drain();
			if ($urandom_range(2) == 0)
				write_mode($urandom_range(1) ? MODE_SKIP : MODE_ALL);
			load_random_curve(1'b0);
			load_random_curve(1'b1);
			if ($urandom_range(4) == 0)
				load_point(1'($urandom), 3'd7, $signed(SAMPLE_W'($urandom)), 0);
			quiet = ($urandom_range(5) == 0);
			burst = $urandom_range(40, 120);
			repeat (burst)
				map_pair(pick_sample(1'b0), pick_sample(1'b1));
			quiet = 1'b0;
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_extremes();
		test_segment_shapes();
		test_random_phases(beats_sent + 1600);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

endmodule
